@@ rtl/s256_pkg.sv @@
// s256_pkg: shared types, constants and helper functions for the sha-256 stream hasher
// no dependencies; imported by s256_round and sha256_stream_hasher
`default_nettype none

package s256_pkg;

  typedef logic [7:0][31:0] hash_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_message;
  } in_t;

  typedef struct packed {
    logic [63:0] digest_part;
    logic [1:0]  part_index;
    logic        last_part;
  } out_t;

  // taps of the 16-word schedule window for one round
  typedef struct packed {
    logic [31:0] w0;
    logic [31:0] w1;
    logic [31:0] w9;
    logic [31:0] w14;
  } sched_t;

  localparam logic [7:0] PAD_MARK = 8'h80;

  localparam hash_t INIT_H = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

endpackage

`default_nettype wire

@@ rtl/s256_round.sv @@
// s256_round: one sha-256 compression round and the next schedule word
// depends on s256_pkg
`default_nettype none

module s256_round import s256_pkg::*; (
  input  wire hash_t       work_i,
  input  wire logic [31:0] k_i,
  input  wire sched_t      sched_i,
  output hash_t            work_o,
  output logic [31:0]      w_new_o
);

  logic [31:0] t1;
  logic [31:0] t2;
  logic [31:0] ch;
  logic [31:0] maj;

  always_comb begin
    ch  = (work_i[4] & work_i[5]) ^ (~work_i[4] & work_i[6]);
    maj = (work_i[0] & work_i[1]) ^ (work_i[0] & work_i[2]) ^ (work_i[1] & work_i[2]);
    t1  = work_i[7] + big_sigma1(work_i[4]) + ch + k_i + sched_i.w0;
    t2  = big_sigma0(work_i[0]) + maj;
    work_o[0] = t1 + t2;
    work_o[1] = work_i[0];
    work_o[2] = work_i[1];
    work_o[3] = work_i[2];
    work_o[4] = work_i[3] + t1;
    work_o[5] = work_i[4];
    work_o[6] = work_i[5];
    work_o[7] = work_i[6];
    w_new_o = small_sigma1(sched_i.w14) + sched_i.w9 + small_sigma0(sched_i.w1) + sched_i.w0;
  end

endmodule

`default_nettype wire

@@ rtl/sha256_stream_hasher.sv @@
// sha256_stream_hasher: byte-serial sha-256 with padding and four-part digest output
// depends on s256_pkg and s256_round
//
//   port group   dir  handshake                  word
//   in_*         in   in_valid_i / in_ready_o    in_t: data_byte, byte_present, end_of_message
//   out_*        out  out_valid_o / out_ready_i  out_t: digest_part, part_index, last_part
//
// one word in per cycle while idle; the 64th byte of a block stalls the input while the
// single shared round unit runs its 64 rounds and the chaining update
// end of message: marker byte, zero padding and the 64-bit length are shifted in, with an
// extra block compressed if 56 or more bytes were in it; the last block is then compressed
// and four digest words go out, one per output handshake; no input word is taken meanwhile
// reset restores the initial hash values and clears length and fill count
`default_nettype none

module sha256_stream_hasher import s256_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire in_t  in_data_i,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output out_t      out_data_o
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MARK = 3'd1;
  localparam logic [2:0] ST_ZERO = 3'd2;
  localparam logic [2:0] ST_LEN  = 3'd3;
  localparam logic [2:0] ST_COMP = 3'd4;
  localparam logic [2:0] ST_FIN  = 3'd5;
  localparam logic [2:0] ST_OUT  = 3'd6;

  logic [2:0]   state_q, state_d;
  logic [2:0]   ret_q, ret_d;
  logic [6:0]   fill_q, fill_d;
  logic [63:0]  bitlen_q, bitlen_d;
  logic [5:0]   round_q, round_d;
  logic [1:0]   part_q, part_d;
  hash_t        chain_q, chain_d;
  hash_t        work_q, work_d;
  logic [511:0] blk_q, blk_d;

  logic         do_shift;
  logic [7:0]   shift_byte;
  hash_t        work_next;
  logic [31:0]  w_new;
  sched_t       sched;

  assign sched.w0  = blk_q[511:480];
  assign sched.w1  = blk_q[479:448];
  assign sched.w9  = blk_q[223:192];
  assign sched.w14 = blk_q[63:32];

  s256_round u_round (
    .work_i  (work_q),
    .k_i     (ROUND_K[round_q]),
    .sched_i (sched),
    .work_o  (work_next),
    .w_new_o (w_new)
  );

  always_comb begin
    state_d    = state_q;
    ret_d      = ret_q;
    fill_d     = fill_q;
    bitlen_d   = bitlen_q;
    round_d    = round_q;
    part_d     = part_q;
    chain_d    = chain_q;
    work_d     = work_q;
    blk_d      = blk_q;
    do_shift   = 1'b0;
    shift_byte = 8'h00;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (in_data_i.byte_present) begin
            do_shift   = 1'b1;
            shift_byte = in_data_i.data_byte;
            bitlen_d   = bitlen_q + 64'd8;
            fill_d     = fill_q + 7'd1;
          end
          if (in_data_i.byte_present && (fill_q == 7'd63)) begin
            state_d = ST_COMP;
            ret_d   = in_data_i.end_of_message ? ST_MARK : ST_IDLE;
            fill_d  = '0;
            work_d  = chain_q;
            round_d = '0;
          end else if (in_data_i.end_of_message) begin
            state_d = ST_MARK;
          end
        end
      end
      ST_MARK: begin
        do_shift   = 1'b1;
        shift_byte = PAD_MARK;
        fill_d     = fill_q + 7'd1;
        state_d    = ST_ZERO;
      end
      ST_ZERO: begin
        if (fill_q == 7'd56) begin
          state_d = ST_LEN;
        end else if (fill_q == 7'd64) begin
          state_d = ST_COMP;
          ret_d   = ST_ZERO;
          fill_d  = '0;
          work_d  = chain_q;
          round_d = '0;
        end else begin
          do_shift = 1'b1;
          fill_d   = fill_q + 7'd1;
        end
      end
      ST_LEN: begin
        do_shift   = 1'b1;
        shift_byte = bitlen_q[63:56];
        bitlen_d   = {bitlen_q[55:0], 8'h00};
        fill_d     = fill_q + 7'd1;
        if (fill_q == 7'd63) begin
          state_d = ST_COMP;
          ret_d   = ST_OUT;
          fill_d  = '0;
          work_d  = chain_q;
          round_d = '0;
        end
      end
      ST_COMP: begin
        work_d  = work_next;
        blk_d   = {blk_q[479:0], w_new};
        round_d = round_q + 6'd1;
        if (round_q == 6'd63) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        for (int i = 0; i < 8; i++) begin
          chain_d[i] = chain_q[i] + work_q[i];
        end
        part_d  = '0;
        state_d = ret_q;
      end
      ST_OUT: begin
        if (out_ready_i) begin
          part_d = part_q + 2'd1;
          for (int i = 0; i < 6; i++) begin
            chain_d[i] = chain_q[i+2];
          end
          if (part_q == 2'd3) begin
            chain_d  = INIT_H;
            bitlen_d = '0;
            fill_d   = '0;
            state_d  = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    if (do_shift) begin
      blk_d = {blk_q[503:0], shift_byte};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      ret_q    <= ST_IDLE;
      fill_q   <= '0;
      bitlen_q <= '0;
      round_q  <= '0;
      part_q   <= '0;
      chain_q  <= INIT_H;
    end else begin
      state_q  <= state_d;
      ret_q    <= ret_d;
      fill_q   <= fill_d;
      bitlen_q <= bitlen_d;
      round_q  <= round_d;
      part_q   <= part_d;
      chain_q  <= chain_d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q <= work_d;
    blk_q  <= blk_d;
  end

  assign in_ready_o             = (state_q == ST_IDLE);
  assign out_valid_o            = (state_q == ST_OUT);
  assign out_data_o.digest_part = {chain_q[0], chain_q[1]};
  assign out_data_o.part_index  = part_q;
  assign out_data_o.last_part   = (part_q == 2'd3);

  // fill count never passes a full block
  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= 7'd64)
    else $error("fill count out of range");

  // the chaining update follows the last of 64 rounds
  a_fin_after_round: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN) |-> ($past(state_q) == ST_COMP && $past(round_q) == 6'd63))
    else $error("chaining update without full compression");

  // last digest word leaves the hasher ready for a new message
  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && out_data_o.last_part)
      |=> (in_ready_o && fill_q == 7'd0 && bitlen_q == 64'd0 && chain_q == INIT_H))
    else $error("state not restored after digest");

  // input and output never both open
  a_one_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input and output open together");

endmodule

`default_nettype wire
